// ===== hdl/mect_pkg.sv =====
// ---------------------------------------------------------------------------
// mect_pkg: shared types and constants of the magnetic edge contact tracker
// Field widths, codes for tracker modes, edges, events and register indexes.
// ---------------------------------------------------------------------------
package mect_pkg;

  // Field widths
  localparam int EDGE_W  = 4;
  localparam int ROT_W   = 16;
  localparam int STR_W   = 16;
  localparam int CONF_W  = 16;
  localparam int TIME_W  = 32;
  localparam int KIND_W  = 3;
  localparam int CNT_W   = 8;
  localparam int MODE_W  = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Stream widths (tdata padded to whole bytes)
  localparam int S_DATA_W = 88;
  localparam int S_USER_W = 1;
  localparam int M_DATA_W = 112;
  localparam int M_USER_W = KIND_W;

  // Tracker modes
  localparam logic [MODE_W-1:0] MODE_IDLE     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_APPROACH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ATTACHED = 2'd2;

  // Edge codes
  localparam logic [EDGE_W-1:0] EDGE_NONE    = 4'd0;
  localparam logic [EDGE_W-1:0] EDGE_TOP     = 4'd1;
  localparam logic [EDGE_W-1:0] EDGE_LEFT    = 4'd4;
  localparam logic [EDGE_W-1:0] EDGE_UNKNOWN = 4'd9;

  // Event kinds
  localparam logic [KIND_W-1:0] EV_APPROACH = 3'd0;
  localparam logic [KIND_W-1:0] EV_CONTACT  = 3'd1;
  localparam logic [KIND_W-1:0] EV_RELEASE  = 3'd2;
  localparam logic [KIND_W-1:0] EV_EDGE     = 3'd3;
  localparam logic [KIND_W-1:0] EV_CW       = 3'd4;
  localparam logic [KIND_W-1:0] EV_CCW      = 3'd5;
  localparam logic [KIND_W-1:0] EV_ORIENT   = 3'd6;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_APPROACH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTACT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STRENGTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIDENCE = 3'd4;

  localparam logic [CNT_W-1:0] COUNT_MAX     = 8'd255;
  localparam logic [CNT_W-1:0] FRAMES_RESET  = 8'd3;

  // Orbit step between cardinal positions
  localparam logic [1:0] STEP_CW  = 2'd1;
  localparam logic [1:0] STEP_CCW = 2'd3;

  typedef struct packed {
    logic [CNT_W-1:0]  approach_frames;
    logic [CNT_W-1:0]  contact_frames;
    logic [CNT_W-1:0]  release_frames_needed;
    logic [STR_W-1:0]  strength_threshold;
    logic [CONF_W-1:0] confidence_threshold;
  } cfg_t;

  typedef struct packed {
    logic              obs_valid;
    logic [EDGE_W-1:0] obs_edge;
    logic [ROT_W-1:0]  obs_rotation;
    logic [STR_W-1:0]  obs_strength;
    logic [CONF_W-1:0] obs_confidence;
    logic              obs_saturated;
    logic [TIME_W-1:0] obs_time_ms;
  } obs_t;

  typedef struct packed {
    logic [KIND_W-1:0] event_kind;
    logic [EDGE_W-1:0] event_edge;
    logic [EDGE_W-1:0] prior_edge;
    logic [ROT_W-1:0]  event_rotation;
    logic [ROT_W-1:0]  prior_rotation;
    logic [STR_W-1:0]  event_strength;
    logic [CONF_W-1:0] event_confidence;
    logic              event_saturated;
    logic [TIME_W-1:0] event_time_ms;
    logic              last_of_run;
  } ev_t;

  // Events caused by one observation: count 0..2, in order
  typedef struct packed {
    logic [1:0] num;
    ev_t        ev0;
    ev_t        ev1;
  } ev_pair_t;

endpackage

// ===== hdl/mect_cfg.sv =====
// ---------------------------------------------------------------------------
// mect_cfg: configuration register file
// Five write-only registers; 8-bit frame counts take the low data byte.
// ---------------------------------------------------------------------------
module mect_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mect_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mect_pkg::CFG_DATA_W-1:0]     cfg_data,
  output mect_pkg::cfg_t                      cfg
);
  import mect_pkg::*;

  // Register writes; unlisted indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.approach_frames       <= FRAMES_RESET;
      cfg.contact_frames        <= FRAMES_RESET;
      cfg.release_frames_needed <= FRAMES_RESET;
      cfg.strength_threshold    <= '0;
      cfg.confidence_threshold  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_APPROACH:   cfg.approach_frames       <= cfg_data[CNT_W-1:0];
        CFG_CONTACT:    cfg.contact_frames        <= cfg_data[CNT_W-1:0];
        CFG_RELEASE:    cfg.release_frames_needed <= cfg_data[CNT_W-1:0];
        CFG_STRENGTH:   cfg.strength_threshold    <= cfg_data[STR_W-1:0];
        CFG_CONFIDENCE: cfg.confidence_threshold  <= cfg_data[CONF_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/mect_core.sv =====
// ---------------------------------------------------------------------------
// mect_core: contact tracker state and event decision
// Qualifies one observation, steps the idle/approach/attached tracker and
// forms the zero, one or two events that the observation causes.
// ---------------------------------------------------------------------------
module mect_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  mect_pkg::obs_t       obs,
  input  mect_pkg::cfg_t       cfg,
  output mect_pkg::ev_pair_t   evs
);
  import mect_pkg::*;

  logic [MODE_W-1:0] mode, mode_next;
  logic [EDGE_W-1:0] cand_edge, cand_edge_next;
  logic [ROT_W-1:0]  cand_rotation, cand_rotation_next;
  logic [CNT_W-1:0]  cand_count, cand_count_next;
  logic [CNT_W-1:0]  release_count, release_count_next;
  logic [EDGE_W-1:0] held_edge, held_edge_next;
  logic [ROT_W-1:0]  held_rotation, held_rotation_next;

  logic             qual;
  logic             cand_match;
  logic [CNT_W-1:0] track_count;
  logic [CNT_W-1:0] rel_inc;
  logic             prior_card, cur_card;
  logic [1:0]       orbit_step;
  ev_t              ev_a, ev_b;
  logic [1:0]       num;

  // Qualification
  assign qual = obs.obs_valid && (obs.obs_edge > EDGE_NONE) &&
                (obs.obs_edge < EDGE_UNKNOWN) &&
                (obs.obs_strength >= cfg.strength_threshold) &&
                (obs.obs_confidence >= cfg.confidence_threshold);

  // Candidate run count, saturating; a new edge/rotation restarts at one
  assign cand_match  = (cand_edge == obs.obs_edge) && (cand_rotation == obs.obs_rotation);
  assign track_count = !cand_match ? CNT_W'(1) :
                       (cand_count < COUNT_MAX) ? cand_count + CNT_W'(1) : cand_count;
  assign rel_inc     = (release_count < COUNT_MAX) ? release_count + CNT_W'(1)
                                                   : release_count;

  // Orbit direction between cardinal edges (top, right, bottom, left)
  assign prior_card = (held_edge >= EDGE_TOP) && (held_edge <= EDGE_LEFT);
  assign cur_card   = (obs.obs_edge >= EDGE_TOP) && (obs.obs_edge <= EDGE_LEFT);
  assign orbit_step = obs.obs_edge[1:0] - held_edge[1:0];

  // Tracker step
  always_comb begin
    mode_next          = mode;
    cand_edge_next     = cand_edge;
    cand_rotation_next = cand_rotation;
    cand_count_next    = cand_count;
    release_count_next = release_count;
    held_edge_next     = held_edge;
    held_rotation_next = held_rotation;
    num                = 2'd0;
    ev_a               = '0;
    ev_b               = '0;

    case (mode)
      MODE_APPROACH: begin
        if (!qual) begin
          mode_next       = MODE_IDLE;
          cand_count_next = '0;
        end else begin
          cand_edge_next     = obs.obs_edge;
          cand_rotation_next = obs.obs_rotation;
          cand_count_next    = track_count;
          if (track_count >= cfg.contact_frames) begin
            mode_next          = MODE_ATTACHED;
            held_edge_next     = obs.obs_edge;
            held_rotation_next = obs.obs_rotation;
            cand_count_next    = '0;
            num                = 2'd1;
            ev_a.event_kind     = EV_CONTACT;
            ev_a.event_edge     = obs.obs_edge;
            ev_a.event_rotation = obs.obs_rotation;
          end
        end
      end

      MODE_ATTACHED: begin
        if (!qual) begin
          release_count_next = rel_inc;
          if (rel_inc >= cfg.release_frames_needed) begin
            // release returns all tracker state to reset
            mode_next          = MODE_IDLE;
            cand_edge_next     = EDGE_NONE;
            cand_rotation_next = '0;
            cand_count_next    = '0;
            release_count_next = '0;
            held_edge_next     = EDGE_NONE;
            held_rotation_next = '0;
            num                = 2'd1;
            ev_a.event_kind     = EV_RELEASE;
            ev_a.prior_edge     = held_edge;
            ev_a.prior_rotation = held_rotation;
          end
        end else begin
          release_count_next = '0;
          if (obs.obs_edge == held_edge && obs.obs_rotation == held_rotation) begin
            cand_count_next = '0;
          end else begin
            cand_edge_next     = obs.obs_edge;
            cand_rotation_next = obs.obs_rotation;
            cand_count_next    = track_count;
            if (track_count >= cfg.contact_frames) begin
              cand_count_next     = '0;
              held_rotation_next  = obs.obs_rotation;
              ev_a.event_edge     = obs.obs_edge;
              ev_a.event_rotation = obs.obs_rotation;
              ev_a.prior_rotation = held_rotation;
              num                 = 2'd1;
              if (obs.obs_edge != held_edge) begin
                held_edge_next  = obs.obs_edge;
                ev_a.event_kind = EV_EDGE;
                ev_a.prior_edge = held_edge;
                ev_b            = ev_a;
                if (prior_card && cur_card) begin
                  if (orbit_step == STEP_CW) begin
                    num             = 2'd2;
                    ev_b.event_kind = EV_CW;
                  end else if (orbit_step == STEP_CCW) begin
                    num             = 2'd2;
                    ev_b.event_kind = EV_CCW;
                  end
                end
              end else begin
                ev_a.event_kind = EV_ORIENT;
                ev_a.prior_edge = obs.obs_edge;
              end
            end
          end
        end
      end

      default: begin
        // idle
        if (!qual) begin
          cand_count_next = '0;
        end else begin
          cand_edge_next     = obs.obs_edge;
          cand_rotation_next = obs.obs_rotation;
          cand_count_next    = track_count;
          if (track_count >= cfg.approach_frames) begin
            mode_next           = MODE_APPROACH;
            cand_count_next     = '0;
            num                 = 2'd1;
            ev_a.event_kind     = EV_APPROACH;
            ev_a.event_edge     = obs.obs_edge;
            ev_a.event_rotation = obs.obs_rotation;
          end
        end
      end
    endcase

    // Pass-through fields and run marks
    ev_a.event_strength   = obs.obs_strength;
    ev_a.event_confidence = obs.obs_confidence;
    ev_a.event_saturated  = obs.obs_saturated;
    ev_a.event_time_ms    = obs.obs_time_ms;
    ev_a.last_of_run      = (num == 2'd1);
    ev_b.event_strength   = obs.obs_strength;
    ev_b.event_confidence = obs.obs_confidence;
    ev_b.event_saturated  = obs.obs_saturated;
    ev_b.event_time_ms    = obs.obs_time_ms;
    ev_b.last_of_run      = 1'b1;
  end

  assign evs.num = num;
  assign evs.ev0 = ev_a;
  assign evs.ev1 = ev_b;

  // State registers, updated on each accepted observation
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      cand_edge     <= EDGE_NONE;
      cand_rotation <= '0;
      cand_count    <= '0;
      release_count <= '0;
      held_edge     <= EDGE_NONE;
      held_rotation <= '0;
    end else if (take) begin
      mode          <= mode_next;
      cand_edge     <= cand_edge_next;
      cand_rotation <= cand_rotation_next;
      cand_count    <= cand_count_next;
      release_count <= release_count_next;
      held_edge     <= held_edge_next;
      held_rotation <= held_rotation_next;
    end
  end

endmodule

// ===== hdl/mect_evq.sv =====
// ---------------------------------------------------------------------------
// mect_evq: event queue
// Four-entry queue; takes up to two events per cycle while room is high, hands out one while out_ready is high.
// ---------------------------------------------------------------------------
module mect_evq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  mect_pkg::ev_pair_t   evs,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mect_pkg::ev_t        out_ev
);
  import mect_pkg::*;

  ev_t        slots [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;
  logic       pop;
  logic [1:0] push_n;

  assign pop       = out_valid && out_ready;
  assign push_n    = push ? evs.num : 2'd0;
  assign out_valid = (count != 3'd0);
  assign room      = (count < 3'd3);
  assign out_ev    = slots[rd_ptr];

  // Entry writes
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      slots[wr_ptr] <= evs.ev0;
    end
    if (push_n == 2'd2) begin
      slots[wr_ptr + 2'd1] <= evs.ev1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n;
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + {1'b0, push_n} - {2'b00, pop};
    end
  end

endmodule

// ===== hdl/magnetic_edge_contact_tracker.sv =====
// ---------------------------------------------------------------------------
// magnetic_edge_contact_tracker: top level
// Debounces magnetometer observations into approach, contact, release,
// edge-change, orbit and orientation events.
//
//   port group | dir | per transfer
//   -----------+-----+--------------------------------------------
//   s_*        | in  | one observation
//   m_*        | out | one event, tlast on the last of a run
//   cfg_*      | in  | one register write, index 0..4
//
// An observation is decided in the cycle it is transferred; its zero, one
// or two events land in a four-entry queue the next edge. s_tready is low
// while fewer than two queue slots are free. One event leaves per cycle
// while m_tready is high. Reset clears the tracker and loads the register
// defaults; m_tready low only stalls the input once fewer than two queue
// slots are free.
// ---------------------------------------------------------------------------
module magnetic_edge_contact_tracker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // edge[3:0], rotation[19:4], strength[35:20], confidence[51:36],
  // saturated[52], time_ms[84:53], zero pad
  input  logic [mect_pkg::S_DATA_W-1:0]      s_tdata,
  // obs_valid[0]
  input  logic [mect_pkg::S_USER_W-1:0]      s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // event_edge[3:0], prior_edge[7:4], event_rotation[23:8],
  // prior_rotation[39:24], strength[55:40], confidence[71:56],
  // saturated[72], time_ms[104:73], zero pad
  output logic [mect_pkg::M_DATA_W-1:0]      m_tdata,
  // event_kind[2:0]
  output logic [mect_pkg::M_USER_W-1:0]      m_tuser,
  output logic                               m_tlast,
  input  logic                               cfg_we,
  input  logic [mect_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mect_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mect_pkg::*;

  cfg_t     cfg;
  obs_t     obs;
  ev_pair_t evs;
  ev_t      out_ev;
  logic     room;
  logic     take;

  assign s_tready = room;
  assign take     = s_tvalid && room;

  // Unpack the observation
  assign obs.obs_valid      = s_tuser[0];
  assign obs.obs_edge       = s_tdata[3:0];
  assign obs.obs_rotation   = s_tdata[19:4];
  assign obs.obs_strength   = s_tdata[35:20];
  assign obs.obs_confidence = s_tdata[51:36];
  assign obs.obs_saturated  = s_tdata[52];
  assign obs.obs_time_ms    = s_tdata[84:53];

  mect_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mect_core u_core (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .obs  (obs),
    .cfg  (cfg),
    .evs  (evs)
  );

  mect_evq u_evq (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .evs       (evs),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_ev    (out_ev)
  );

  // Pack the event
  assign m_tuser = out_ev.event_kind;
  assign m_tlast = out_ev.last_of_run;
  assign m_tdata = {7'd0,
                    out_ev.event_time_ms,
                    out_ev.event_saturated,
                    out_ev.event_confidence,
                    out_ev.event_strength,
                    out_ev.prior_rotation,
                    out_ev.event_rotation,
                    out_ev.prior_edge,
                    out_ev.event_edge};

endmodule
